>>> rtl/core/lsm2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsm2d_pkg
// Shared types and constants of the 2-D least-squares multilateration unit.
// ----------------------------------------------------------------------------
package lsm2d_pkg;

   // Largest number of beacons per run
   localparam int MAX_ANCHORS = 8;
   localparam int CNT_W       = 4;
   localparam logic [31:0] THR_RESET = 32'd4295;

   // Per-beacon multiply operations (one per cycle on the narrow multiplier)
   typedef enum logic [3:0] {
      OP_NONE, OP_RR, OP_BR, OP_RX, OP_BX, OP_RY, OP_BY,
      OP_XX, OP_XY, OP_YY, OP_XB, OP_YB
   } mul_op_type;

   // Wide products of the solve, in issue order
   typedef enum logic [2:0] {
      WP_XX_YY, WP_XY_XY, WP_BX_YY, WP_BY_XY, WP_BY_XX, WP_BX_XY
   } wide_prod_type;

   typedef enum logic [1:0] {
      ST_OK, ST_SHORT, ST_SINGULAR, ST_TOO_MANY
   } status_type;

   // Controller to datapath
   typedef struct packed {
      logic          capture;
      logic          load_ref;
      mul_op_type    mul_op;
      logic          clear_sums;
      logic          clear_wide;
      logic          wide_start;
      wide_prod_type wide_sel;
      logic          det_abs;
      logic          div_start;
      logic          div_sel_y;
      logic          load_out;
      status_type    out_status;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic wide_busy;
      logic div_busy;
      logic singular;
   } sts_type;

endpackage

>>> rtl/core/least_squares_multilateration_2d_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_squares_multilateration_2d_unit
// Top level: 2-D linear least-squares multilateration over a run of beacons.
// ----------------------------------------------------------------------------
// Beacons arrive one per beat (Q8.8 position and range); the first of a run is
// the reference, each later one up to MAX_ANCHORS beacons adds its row to the
// normal equations. A beat taking the reference or an excess beacon only
// registers it; any other beacon runs the single narrow multiplier through
// eleven products, one per cycle. The beat flagged tlast then solves: six
// products in the shift-add wide multiplier for the determinant and
// numerators, then two restoring divides; short or oversized runs report at
// once, singular ones once the determinant is known. One result beat per run;
// the result register holds it while the next run's beacons are taken in.
// ----------------------------------------------------------------------------
module least_squares_multilateration_2d_unit import lsm2d_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // beacon_x, beacon_y, beacon_range
   input  logic        req_tlast,   // last_beacon
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // pos_x, pos_y
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data     // det_threshold
);

   cmd_type cmd;
   sts_type sts;
   logic [15:0] pos_x, pos_y;

   assign csr_ready = 1'b1;

   // sequencer
   lsm2d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_last  (req_tlast),
      .req_ready (req_tready),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic
   lsm2d_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .beat_x     (req_tdata[15:0]),
      .beat_y     (req_tdata[31:16]),
      .beat_range (req_tdata[47:32]),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .pos_x      (pos_x),
      .pos_y      (pos_y),
      .status     (rsp_tuser)
   );

   assign rsp_tdata = {pos_y, pos_x};

endmodule

>>> rtl/core/lsm2d_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsm2d_datapath
// Beacon registers, normal-equation sums, narrow MAC, serial wide multiplier
// and restoring divider of the multilateration unit.
// ----------------------------------------------------------------------------
module lsm2d_datapath import lsm2d_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [15:0] beat_x,
   input  logic [15:0] beat_y,
   input  logic [15:0] beat_range,
   input  logic        csr_valid,
   input  logic [31:0] csr_data,
   output logic [15:0] pos_x,
   output logic [15:0] pos_y,
   output logic [1:0]  status
);

   // threshold register
   logic [31:0] thr_ff;

   // beat and reference
   logic signed [15:0] bx_ff, by_ff, rx_ff, ry_ff;
   logic        [15:0] br_ff, rr_ff;

   // sums
   logic signed [35:0] b_ff;
   logic signed [39:0] sxx_ff, sxy_ff, syy_ff;
   logic signed [55:0] sbx_ff, sby_ff;

   // narrow multiplier pipeline
   logic signed [17:0] ma;
   logic signed [35:0] mb;
   logic signed [53:0] prod_ff;
   mul_op_type         pop_ff;
   logic signed [16:0] dx, dy;
   logic signed [17:0] ax, ay;

   // serial wide multiplier
   logic signed [55:0] wsa;
   logic signed [39:0] wsb;
   logic               wsub;
   logic        [55:0] wa_mag;
   logic        [39:0] wb_mag;
   logic        [95:0] wa_ff, wprod_ff;
   logic        [39:0] wb_ff;
   logic               wneg_ff, wacc_ff;
   logic        [5:0]  wcnt_ff;
   wide_prod_type      wsel_ff;
   logic signed [97:0] det_ff, nx_ff, ny_ff, wterm;
   logic        [97:0] det_mag_ff;

   // divider
   logic signed [97:0] dnum;
   logic        [97:0] dnum_mag;
   logic       [103:0] rem_ff, ds_ff;
   logic        [18:0] q_ff, q_in, qx_ff, qy_ff;
   logic        [4:0]  dcnt_ff;
   logic               dneg_ff, dsel_ff, xneg_ff, yneg_ff;

   // output
   logic [15:0] posx_ff, posy_ff;
   logic [1:0]  stat_ff;

   // Saturate a quotient magnitude to Q8.8 and apply its sign
   function automatic logic [15:0] sat_q88(input logic [18:0] q, input logic neg);
      logic [18:0] limit;
      logic [15:0] mag;
      limit = neg ? 19'd32768 : 19'd32767;
      mag   = (q > limit) ? limit[15:0] : q[15:0];
      return neg ? 16'(-mag) : mag;
   endfunction

   // linearised row terms
   assign dx = 17'(bx_ff) - 17'(rx_ff);
   assign dy = 17'(by_ff) - 17'(ry_ff);
   assign ax = {dx, 1'b0};
   assign ay = {dy, 1'b0};

   // narrow multiplier operand select
   always_comb begin
      ma = '0;
      mb = '0;
      case (cmd.mul_op)
         OP_RR: begin ma = {2'b00, rr_ff}; mb = 36'({2'b00, rr_ff}); end
         OP_BR: begin ma = {2'b00, br_ff}; mb = -36'({2'b00, br_ff}); end
         OP_RX: begin ma = 18'(rx_ff); mb = -36'(rx_ff); end
         OP_BX: begin ma = 18'(bx_ff); mb = 36'(bx_ff); end
         OP_RY: begin ma = 18'(ry_ff); mb = -36'(ry_ff); end
         OP_BY: begin ma = 18'(by_ff); mb = 36'(by_ff); end
         OP_XX: begin ma = ax; mb = 36'(ax); end
         OP_XY: begin ma = ax; mb = 36'(ay); end
         OP_YY: begin ma = ay; mb = 36'(ay); end
         OP_XB: begin ma = ax; mb = b_ff; end
         OP_YB: begin ma = ay; mb = b_ff; end
         default: begin ma = '0; mb = '0; end
      endcase
   end

   // wide multiplier operand select
   always_comb begin
      wsa  = '0;
      wsb  = '0;
      wsub = 1'b0;
      case (cmd.wide_sel)
         WP_XX_YY: begin wsa = 56'(sxx_ff); wsb = syy_ff; end
         WP_XY_XY: begin wsa = 56'(sxy_ff); wsb = sxy_ff; wsub = 1'b1; end
         WP_BX_YY: begin wsa = sbx_ff; wsb = syy_ff; end
         WP_BY_XY: begin wsa = sby_ff; wsb = sxy_ff; wsub = 1'b1; end
         WP_BY_XX: begin wsa = sby_ff; wsb = sxx_ff; end
         WP_BX_XY: begin wsa = sbx_ff; wsb = sxy_ff; wsub = 1'b1; end
         default:  begin wsa = '0; wsb = '0; wsub = 1'b0; end
      endcase
   end
   assign wa_mag = wsa[55] ? 56'(-wsa) : 56'(wsa);
   assign wb_mag = wsb[39] ? 40'(-wsb) : 40'(wsb);
   assign wterm  = wneg_ff ? -signed'({2'b00, wprod_ff}) : signed'({2'b00, wprod_ff});

   // divider helpers
   assign dnum     = cmd.div_sel_y ? ny_ff : nx_ff;
   assign dnum_mag = dnum[97] ? 98'(-dnum) : 98'(dnum);
   assign q_in     = {q_ff[17:0], (rem_ff >= ds_ff)};

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= THR_RESET;
         pop_ff   <= OP_NONE;
         wcnt_ff  <= '0;
         wacc_ff  <= 1'b0;
         dcnt_ff  <= '0;
         b_ff     <= '0;
         sxx_ff   <= '0;
         sxy_ff   <= '0;
         syy_ff   <= '0;
         sbx_ff   <= '0;
         sby_ff   <= '0;
      end else begin
         if (csr_valid) thr_ff <= csr_data;
         pop_ff <= cmd.mul_op;

         // accumulate previous cycle's product
         if (cmd.capture) b_ff <= '0;
         case (pop_ff)
            OP_RR, OP_BR, OP_RX, OP_BX, OP_RY, OP_BY: b_ff <= b_ff + prod_ff[35:0];
            OP_XX: sxx_ff <= sxx_ff + prod_ff[39:0];
            OP_XY: sxy_ff <= sxy_ff + prod_ff[39:0];
            OP_YY: syy_ff <= syy_ff + prod_ff[39:0];
            OP_XB: sbx_ff <= sbx_ff + 56'(prod_ff);
            OP_YB: sby_ff <= sby_ff + 56'(prod_ff);
            default: ;
         endcase
         if (cmd.clear_sums) begin
            sxx_ff <= '0;
            sxy_ff <= '0;
            syy_ff <= '0;
            sbx_ff <= '0;
            sby_ff <= '0;
         end

         // wide multiplier sequencing
         if (cmd.wide_start) begin
            wcnt_ff <= 6'd40;
         end else if (wcnt_ff != '0) begin
            wcnt_ff <= wcnt_ff - 6'd1;
         end
         wacc_ff <= (wcnt_ff == 6'd1);

         // divider sequencing: one init step then 19 quotient bits
         if (cmd.div_start) begin
            dcnt_ff <= 5'd20;
         end else if (dcnt_ff != '0) begin
            dcnt_ff <= dcnt_ff - 5'd1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         bx_ff <= beat_x;
         by_ff <= beat_y;
         br_ff <= beat_range;
      end
      if (cmd.load_ref) begin
         rx_ff <= beat_x;
         ry_ff <= beat_y;
         rr_ff <= beat_range;
      end
      prod_ff <= ma * mb;

      // serial shift-add multiply
      if (cmd.wide_start) begin
         wa_ff    <= 96'(wa_mag);
         wb_ff    <= wb_mag;
         wneg_ff  <= wsa[55] ^ wsb[39] ^ wsub;
         wsel_ff  <= cmd.wide_sel;
         wprod_ff <= '0;
      end else if (wcnt_ff != '0) begin
         if (wb_ff[0]) wprod_ff <= wprod_ff + wa_ff;
         wa_ff <= {wa_ff[94:0], 1'b0};
         wb_ff <= {1'b0, wb_ff[39:1]};
      end
      if (cmd.clear_wide) begin
         det_ff <= '0;
         nx_ff  <= '0;
         ny_ff  <= '0;
      end else if (wacc_ff) begin
         case (wsel_ff)
            WP_XX_YY, WP_XY_XY: det_ff <= det_ff + wterm;
            WP_BX_YY, WP_BY_XY: nx_ff  <= nx_ff + wterm;
            default:            ny_ff  <= ny_ff + wterm;
         endcase
      end
      if (cmd.det_abs) det_mag_ff <= det_ff[97] ? 98'(-det_ff) : 98'(det_ff);

      // restoring divide of (2n+d) by 2d
      if (cmd.div_start) begin
         rem_ff  <= 104'(dnum_mag);
         dneg_ff <= dnum[97] ^ det_ff[97];
         dsel_ff <= cmd.div_sel_y;
         q_ff    <= '0;
      end else if (dcnt_ff == 5'd20) begin
         rem_ff <= {rem_ff[102:0], 1'b0} + 104'(det_mag_ff);
         ds_ff  <= 104'(det_mag_ff) << 19;
      end else if (dcnt_ff != '0) begin
         if (rem_ff >= ds_ff) rem_ff <= rem_ff - ds_ff;
         ds_ff <= {1'b0, ds_ff[103:1]};
         q_ff  <= q_in;
         if (dcnt_ff == 5'd1) begin
            if (dsel_ff) begin
               qy_ff   <= q_in;
               yneg_ff <= dneg_ff;
            end else begin
               qx_ff   <= q_in;
               xneg_ff <= dneg_ff;
            end
         end
      end

      // result register
      if (cmd.load_out) begin
         stat_ff <= cmd.out_status;
         posx_ff <= (cmd.out_status == ST_OK) ? sat_q88(qx_ff, xneg_ff) : '0;
         posy_ff <= (cmd.out_status == ST_OK) ? sat_q88(qy_ff, yneg_ff) : '0;
      end
   end

   assign sts.wide_busy = (wcnt_ff != '0) || wacc_ff;
   assign sts.div_busy  = (dcnt_ff != '0);
   assign sts.singular  = (det_mag_ff == '0) || (det_mag_ff < 98'(thr_ff));

   assign pos_x  = posx_ff;
   assign pos_y  = posy_ff;
   assign status = stat_ff;

endmodule

>>> rtl/core/lsm2d_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsm2d_ctrl
// Sequencer of the multilateration unit: beat intake, per-beacon MAC
// schedule, solve sequence and result handshake.
// ----------------------------------------------------------------------------
module lsm2d_ctrl import lsm2d_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_last,
   output logic    req_ready,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_ACC, S_DECIDE, S_WSTART, S_WWAIT,
      S_DABS, S_DCHK, S_QSTART, S_QWAIT, S_EMIT
   } state_type;

   localparam logic [3:0] ACC_LAST = 4'd11;

   state_type      state_ff;
   logic [3:0]     step_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic           many_ff, last_ff, qy_ff, rsp_valid_ff;
   wide_prod_type  wsel_ff;
   status_type     stat_ff;
   logic           accept, emit;

   // MAC schedule: six squares for b, then the row products
   function automatic mul_op_type op_at(input logic [3:0] s);
      case (s)
         4'd0:    return OP_RR;
         4'd1:    return OP_BR;
         4'd2:    return OP_RX;
         4'd3:    return OP_BX;
         4'd4:    return OP_RY;
         4'd5:    return OP_BY;
         4'd6:    return OP_XX;
         4'd7:    return OP_XY;
         4'd8:    return OP_YY;
         4'd9:    return OP_XB;
         4'd10:   return OP_YB;
         default: return OP_NONE;
      endcase
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign emit      = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   // command decode
   always_comb begin
      cmd            = '0;
      cmd.mul_op     = OP_NONE;
      cmd.wide_sel   = wsel_ff;
      cmd.div_sel_y  = qy_ff;
      cmd.out_status = stat_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.capture  = accept;
            cmd.load_ref = accept && (cnt_ff == '0);
         end
         S_ACC:    cmd.mul_op = op_at(step_ff);
         S_DECIDE: cmd.clear_wide = !many_ff && (cnt_ff >= CNT_W'(3));
         S_WSTART: cmd.wide_start = 1'b1;
         S_DABS:   cmd.det_abs = 1'b1;
         S_QSTART: cmd.div_start = 1'b1;
         S_EMIT: begin
            cmd.load_out   = emit;
            cmd.clear_sums = emit;
         end
         default: ;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         cnt_ff       <= '0;
         many_ff      <= 1'b0;
         last_ff      <= 1'b0;
         qy_ff        <= 1'b0;
         wsel_ff      <= WP_XX_YY;
         stat_ff      <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !emit) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  last_ff <= req_last;
                  if (cnt_ff >= CNT_W'(MAX_ANCHORS)) begin
                     many_ff  <= 1'b1;
                     state_ff <= req_last ? S_DECIDE : S_IDLE;
                  end else if (cnt_ff == '0) begin
                     cnt_ff   <= CNT_W'(1);
                     state_ff <= req_last ? S_DECIDE : S_IDLE;
                  end else begin
                     cnt_ff   <= cnt_ff + CNT_W'(1);
                     step_ff  <= '0;
                     state_ff <= S_ACC;
                  end
               end
            end
            S_ACC: begin
               step_ff <= step_ff + 4'd1;
               if (step_ff == ACC_LAST) state_ff <= last_ff ? S_DECIDE : S_IDLE;
            end
            S_DECIDE: begin
               if (many_ff) begin
                  stat_ff  <= ST_TOO_MANY;
                  state_ff <= S_EMIT;
               end else if (cnt_ff < CNT_W'(3)) begin
                  stat_ff  <= ST_SHORT;
                  state_ff <= S_EMIT;
               end else begin
                  wsel_ff  <= WP_XX_YY;
                  state_ff <= S_WSTART;
               end
            end
            S_WSTART: state_ff <= S_WWAIT;
            S_WWAIT: begin
               if (!sts.wide_busy) begin
                  case (wsel_ff)
                     WP_XX_YY: begin wsel_ff <= WP_XY_XY; state_ff <= S_WSTART; end
                     WP_XY_XY: begin wsel_ff <= WP_BX_YY; state_ff <= S_WSTART; end
                     WP_BX_YY: begin wsel_ff <= WP_BY_XY; state_ff <= S_WSTART; end
                     WP_BY_XY: begin wsel_ff <= WP_BY_XX; state_ff <= S_WSTART; end
                     WP_BY_XX: begin wsel_ff <= WP_BX_XY; state_ff <= S_WSTART; end
                     default:  state_ff <= S_DABS;
                  endcase
               end
            end
            S_DABS: state_ff <= S_DCHK;
            S_DCHK: begin
               if (sts.singular) begin
                  stat_ff  <= ST_SINGULAR;
                  state_ff <= S_EMIT;
               end else begin
                  qy_ff    <= 1'b0;
                  state_ff <= S_QSTART;
               end
            end
            S_QSTART: state_ff <= S_QWAIT;
            S_QWAIT: begin
               if (!sts.div_busy) begin
                  if (qy_ff) begin
                     stat_ff  <= ST_OK;
                     state_ff <= S_EMIT;
                  end else begin
                     qy_ff    <= 1'b1;
                     state_ff <= S_QSTART;
                  end
               end
            end
            S_EMIT: begin
               if (emit) begin
                  rsp_valid_ff <= 1'b1;
                  cnt_ff       <= '0;
                  many_ff      <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // beacon count never passes the bound
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_ANCHORS))
      else $error("beacon count above bound");

   // a loaded result is offered on the next cycle
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("result loaded but not offered");

   // no solve unit still running once back in idle
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !(sts.wide_busy || sts.div_busy))
      else $error("solve unit busy in idle");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 2-D least-squares multilateration unit.
// ----------------------------------------------------------------------------
// Beacon runs are queued by a stimulus block and fed to the unit by a clocked
// driver. A bit-exact predictor follows every accepted beacon, keeps its own
// running normal-equation sums and, on each run's last beacon, solves for the
// position and queues the expected result. A monitor checks each result beat
// against the oldest queued result. Both sides stall at random, except in a
// calm phase. The threshold is rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_top;
   import lsm2d_pkg::*;

   localparam int IDLE_PCT = 35;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        range;
      logic               last;
   } beacon_type;

   typedef struct {
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      status_type  status;
   } fix_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;

   beacon_type beacon_q[$];
   fix_type    fix_q[$];
   int      errors = 0;
   bit      calm = 1'b0;

   // Predictor state
   logic [31:0] pred_thr;
   longint      anchor_x, anchor_y, anchor_r;
   int          n_beacons;
   bit          overflowed;
   longint      s_xx, s_xy, s_yy, s_bx, s_by;

   least_squares_multilateration_2d_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit stall();
      return !calm && ($urandom_range(99) < IDLE_PCT);
   endfunction

   function automatic void clear_run();
      anchor_x = 0; anchor_y = 0; anchor_r = 0;
      n_beacons = 0; overflowed = 0;
      s_xx = 0; s_xy = 0; s_yy = 0; s_bx = 0; s_by = 0;
   endfunction

   // num / den rounded half away from zero, saturated to Q8.8
   function automatic logic [15:0] q88_quotient(logic signed [127:0] num,
                                                logic signed [127:0] den);
      logic        neg;
      logic [127:0] n, d, q, lim;
      neg = num[127] ^ den[127];
      n   = num[127] ? -num : num;
      d   = den[127] ? -den : den;
      q   = ((n << 1) + d) / (d << 1);
      lim = neg ? 128'd32768 : 128'd32767;
      if (q > lim) q = lim;
      return neg ? 16'(-q) : q[15:0];
   endfunction

   // Follow one accepted beacon; queue a fix on the last one
   function automatic void track_beacon(beacon_type b);
      longint bx, by, br, ax, ay, rhs;
      logic signed [127:0] xx, xy, yy, bxs, bys, det, mag, nx, ny;
      fix_type f;
      bx = b.x; by = b.y; br = b.range;
      if (n_beacons >= MAX_ANCHORS) begin
         overflowed = 1;
      end else if (n_beacons == 0) begin
         anchor_x = bx; anchor_y = by; anchor_r = br;
         n_beacons = 1;
      end else begin
         ax  = 2 * (bx - anchor_x);
         ay  = 2 * (by - anchor_y);
         rhs = anchor_r * anchor_r - br * br - anchor_x * anchor_x + bx * bx
             - anchor_y * anchor_y + by * by;
         s_xx += ax * ax;  s_xy += ax * ay;  s_yy += ay * ay;
         s_bx += ax * rhs; s_by += ay * rhs;
         n_beacons++;
      end
      if (!b.last) return;
      f.pos_x = '0; f.pos_y = '0;
      if (overflowed) f.status = ST_TOO_MANY;
      else if (n_beacons < 3) f.status = ST_SHORT;
      else begin
         xx = s_xx; xy = s_xy; yy = s_yy; bxs = s_bx; bys = s_by;
         det = xx * yy - xy * xy;
         mag = det[127] ? -det : det;
         if (mag == 0 || mag < pred_thr) f.status = ST_SINGULAR;
         else begin
            nx = bxs * yy - bys * xy;
            ny = bys * xx - bxs * xy;
            f.pos_x  = q88_quotient(nx, det);
            f.pos_y  = q88_quotient(ny, det);
            f.status = ST_OK;
         end
      end
      fix_q.push_back(f);
      clear_run();
   endfunction

   function automatic void flag(string what);
      errors++;
      if (errors <= 10) $display("MISMATCH %s at %0t", what, $realtime);
   endfunction

   // Beacon driver
   always @(posedge clock) begin
      beacon_type b;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            track_beacon('{req_tdata[15:0], req_tdata[31:16], req_tdata[47:32],
                           req_tlast});
         if (!req_tvalid || req_tready) begin
            if (beacon_q.size() != 0 && !stall()) begin
               b = beacon_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {b.range, b.y, b.x};
               req_tlast  <= b.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      fix_type f;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (fix_q.size() == 0) begin
               flag($sformatf("unexpected result %h/%0d", rsp_tdata, rsp_tuser));
            end else begin
               f = fix_q.pop_front();
               if (rsp_tdata[15:0] !== f.pos_x)
                  flag($sformatf("pos_x exp %h got %h", f.pos_x, rsp_tdata[15:0]));
               if (rsp_tdata[31:16] !== f.pos_y)
                  flag($sformatf("pos_y exp %h got %h", f.pos_y, rsp_tdata[31:16]));
               if (rsp_tuser !== f.status)
                  flag($sformatf("status exp %0d got %0d", f.status, rsp_tuser));
            end
         end
         rsp_tready <= !stall();
      end
   end

   function automatic void add_beacon(int x, int y, int r, bit last);
      beacon_type b;
      b.x = 16'(x); b.y = 16'(y); b.range = 16'(r); b.last = last;
      beacon_q.push_back(b);
   endfunction

   // Run of n beacons around a true point; mode 0 consistent, 1 raw, 2 collinear
   function automatic void add_run(int n, int mode);
      int  px, py, span, x, y, r, k;
      real d;
      span = $urandom_range(3) == 0 ? 32767 : $urandom_range(4000, 64);
      px = $urandom_range(2 * span) - span;
      py = $urandom_range(2 * span) - span;
      k  = $urandom_range(7) - 3;
      for (int i = 0; i < n; i++) begin
         if (mode == 1) begin
            x = $urandom_range(65535) - 32768;
            y = $urandom_range(65535) - 32768;
            r = $urandom_range(65535);
         end else begin
            x = $urandom_range(2 * span) - span;
            y = (mode == 2) ? k * (x / 4) : $urandom_range(2 * span) - span;
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            d = $sqrt(real'(x - px) * real'(x - px) + real'(y - py) * real'(y - py));
            r = int'(d) + $urandom_range(16) - 8;
            if (r < 0) r = 0;
            if (r > 65535) r = 65535;
         end
         add_beacon(x, y, r, i == n - 1);
      end
   endfunction

   task automatic wait_idle();
      while (beacon_q.size() != 0 || req_tvalid || fix_q.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_threshold(logic [31:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      pred_thr = v;
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [31:0] thr_set[5];
      int n;
      pred_thr = THR_RESET;
      clear_run();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: good fix, extremes, short runs, singular, overflow, full run
      add_beacon(0, 0, 1280, 0); add_beacon(2560, 0, 2048, 0);
      add_beacon(0, 2560, 1621, 1);
      add_beacon(-32768, -32768, 0, 0); add_beacon(32767, -32768, 65535, 0);
      add_beacon(-32768, 32767, 65535, 0); add_beacon(32767, 32767, 0, 1);
      add_beacon(100, 100, 5, 1);
      add_beacon(100, 100, 5, 0); add_beacon(-100, 200, 7, 1);
      add_beacon(0, 0, 10, 0); add_beacon(256, 256, 10, 0);
      add_beacon(512, 512, 10, 1);
      for (int i = 0; i < 9; i++) add_beacon(i * 300, (i * i) * 50, 700, i == 8);
      for (int i = 0; i < 8; i++) add_beacon(-i * 200, i * i * 40, 900, i == 7);
      wait_idle();

      thr_set = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0010_0000, THR_RESET};
      for (int ph = 0; ph < 5; ph++) begin
         write_threshold(ph == 3 ? $urandom : thr_set[ph]);
         n = 0;
         while (n < 205) begin
            calm = (ph == 2);
            case ($urandom_range(9))
               0: begin
                  add_run($urandom_range(2, 1), 0); n += 2;
               end
               1: begin
                  add_run($urandom_range(12, 9), $urandom_range(1)); n += 10;
               end
               2: begin
                  add_run($urandom_range(8, 3), 2); n += 5;
               end
               3: begin
                  add_run($urandom_range(8, 3), 1); n += 5;
               end
               default: begin
                  add_run($urandom_range(8, 3), 0); n += 5;
               end
            endcase
         end
         wait_idle();
      end
      calm = 0;

      repeat (400) @(posedge clock);
      if (fix_q.size() != 0) flag("results left over");
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/lsm2d_pkg.sv
rtl/core/lsm2d_datapath.sv
rtl/core/lsm2d_ctrl.sv
rtl/core/least_squares_multilateration_2d_unit.sv
tb/sv/tb_top.sv
